// ===== design/am_pkg.sv =====
`timescale 1ns / 1ps
// shared types for the accumulator machine execute unit
// opcode and status codes, divider request and response bundles; no dependencies

package am_pkg;

  typedef enum logic [3:0] {
    OP_JUMP   = 4'd0,
    OP_JPNEG  = 4'd1,
    OP_JPZERO = 4'd2,
    OP_READ   = 4'd3,
    OP_WRITE  = 4'd4,
    OP_MOV    = 4'd5,
    OP_LOAD   = 4'd6,
    OP_STORE  = 4'd7,
    OP_ADD    = 4'd8,
    OP_SUB    = 4'd9,
    OP_MUL    = 4'd10,
    OP_DIV    = 4'd11,
    OP_REM    = 4'd12,
    OP_HALT   = 4'd13
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OP     = 2'd1,
    ST_DIV_ZERO   = 2'd2,
    ST_JUMP_RANGE = 2'd3
  } status_e;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== design/accumulator_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// execute unit of a small accumulator machine: accumulator, variable store, line counter
// depends on am_pkg and am_div
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  opcode, operands, literal, read value
//  out      output     out_valid_o / out_stall_i next line, write value, acc, status, halt
//
// one instruction at a time: accept, store read, execute, result load;
// div and rem with a nonzero operand add a pass through the shared divider before result load.
// the variable store is a ram with one valid bit per slot, cleared at reset.
// a waiting result holds in the output register; the next item is taken meanwhile.

module accumulator_machine_execute_unit #(
  parameter int unsigned VARIABLES = 16,
  parameter int unsigned LINES     = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         opcode_i,
  input  logic               var_valid_i,
  input  logic [3:0]         var_index_i,
  input  logic               src_is_var_i,
  input  logic [3:0]         src_index_i,
  input  logic signed [31:0] literal_i,
  input  logic signed [31:0] read_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         next_line_o,
  output logic               write_valid_o,
  output logic signed [31:0] write_value_o,
  output logic signed [31:0] acc_value_o,
  output logic [1:0]         status_o,
  output logic               halted_o
);
  import am_pkg::*;

  // only slots reachable by a 4-bit index get storage
  localparam int unsigned Slots = (VARIABLES < 16) ? VARIABLES : 16;
  localparam int unsigned AddrW = $clog2(Slots);
  localparam int unsigned LineW = (LINES > 2) ? $clog2(LINES) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q;

  logic [3:0]        op_q;
  logic              var_valid_q;
  logic [3:0]        vidx_q;
  logic              src_is_var_q;
  logic [3:0]        sidx_q;
  logic [DataW-1:0]  lit_q;
  logic [DataW-1:0]  rdv_q;

  logic [DataW-1:0]  mem [Slots];
  logic [Slots-1:0]  slot_ok_q;
  logic [DataW-1:0]  rd_a_q;
  logic [DataW-1:0]  rd_b_q;

  logic [DataW-1:0]  acc_q;
  logic [LineW-1:0]  line_q;

  logic              div_neg_q;
  logic              div_rem_q;

  logic [1:0]        res_status_q;
  logic              res_wvalid_q;
  logic [DataW-1:0]  res_wval_q;
  logic              res_halt_q;

  logic              out_valid_q;
  logic [7:0]        out_line_q;
  logic              out_wvalid_q;
  logic [DataW-1:0]  out_wval_q;
  logic [DataW-1:0]  out_acc_q;
  logic [1:0]        out_status_q;
  logic              out_halt_q;

  logic              in_xfer;
  logic              out_free;
  logic              a_in_range;
  logic              b_in_range;
  logic [DataW-1:0]  val_a;
  logic [DataW-1:0]  val_b;
  logic [DataW-1:0]  opnd;
  logic [LineW:0]    line_inc;
  logic [LineW-1:0]  nxt;
  logic              take;
  status_e           status;
  logic              we;
  logic [DataW-1:0]  wdata;
  logic              wvalid;
  logic [DataW-1:0]  wval;
  logic              halt;
  logic [DataW-1:0]  acc_new;
  logic              div_go;
  logic [DataW-1:0]  prod;
  logic [DataW-1:0]  div_res;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign a_in_range = (int'(vidx_q) < int'(VARIABLES));
  assign b_in_range = (int'(sidx_q) < int'(VARIABLES));
  assign val_a = (a_in_range && slot_ok_q[vidx_q[AddrW-1:0]]) ? rd_a_q : '0;
  assign val_b = (b_in_range && slot_ok_q[sidx_q[AddrW-1:0]]) ? rd_b_q : '0;
  assign opnd  = var_valid_q ? val_a : lit_q;
  assign prod  = acc_q * opnd;

  assign line_inc = {1'b0, line_q} + 1'b1;

  always_comb begin
    take    = 1'b0;
    status  = ST_OK;
    we      = 1'b0;
    wdata   = '0;
    wvalid  = 1'b0;
    wval    = '0;
    halt    = 1'b0;
    acc_new = acc_q;
    div_go  = 1'b0;
    nxt     = (32'(line_inc) >= 32'(LINES)) ? '0 : line_inc[LineW-1:0];
    case (opcode_e'(op_q))
      OP_JUMP:   take = 1'b1;
      OP_JPNEG:  take = acc_q[DataW-1];
      OP_JPZERO: take = (acc_q == '0);
      OP_READ: begin
        we    = 1'b1;
        wdata = rdv_q;
      end
      OP_WRITE: begin
        wvalid = 1'b1;
        wval   = val_a;
      end
      OP_MOV: begin
        we    = 1'b1;
        wdata = src_is_var_q ? val_b : lit_q;
      end
      OP_LOAD:  acc_new = val_a;
      OP_STORE: begin
        we    = 1'b1;
        wdata = acc_q;
      end
      OP_ADD: acc_new = acc_q + opnd;
      OP_SUB: acc_new = acc_q - opnd;
      OP_MUL: acc_new = prod;
      OP_DIV, OP_REM: begin
        if (opnd == '0) begin
          status = ST_DIV_ZERO;
        end else begin
          div_go = 1'b1;
        end
      end
      OP_HALT: halt = 1'b1;
      default: status = ST_BAD_OP;
    endcase
    if (take) begin
      if (lit_q[DataW-1] || (lit_q >= 32'(LINES))) begin
        status = ST_JUMP_RANGE;
      end else begin
        nxt = lit_q[LineW-1:0];
      end
    end
  end

  assign div_req.start    = (state_q == S_EXEC) && div_go;
  assign div_req.dividend = acc_q[DataW-1] ? (~acc_q + 1'b1) : acc_q;
  assign div_req.divisor  = opnd[DataW-1] ? (~opnd + 1'b1) : opnd;

  am_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (div_rem_q) begin
      div_res = div_neg_q ? (~div_rsp.remainder + 1'b1) : div_rsp.remainder;
    end else begin
      div_res = div_neg_q ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
    end
  end

  // store ram: write at execute, both operand reads registered
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_a_q <= mem[vidx_q[AddrW-1:0]];
      rd_b_q <= mem[sidx_q[AddrW-1:0]];
    end
    if ((state_q == S_EXEC) && we && (status == ST_OK) && a_in_range) begin
      mem[vidx_q[AddrW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q         <= opcode_i;
      var_valid_q  <= var_valid_i;
      vidx_q       <= var_index_i;
      src_is_var_q <= src_is_var_i;
      sidx_q       <= src_index_i;
      lit_q        <= literal_i;
      rdv_q        <= read_value_i;
    end
    if (state_q == S_EXEC) begin
      res_status_q <= status;
      res_wvalid_q <= wvalid;
      res_wval_q   <= wval;
      res_halt_q   <= halt;
      div_rem_q    <= (opcode_e'(op_q) == OP_REM);
      div_neg_q    <= (opcode_e'(op_q) == OP_REM) ? acc_q[DataW-1]
                                                  : (acc_q[DataW-1] ^ opnd[DataW-1]);
    end
    if ((state_q == S_FINISH) && out_free) begin
      out_line_q   <= 8'(line_q);
      out_wvalid_q <= res_wvalid_q;
      out_wval_q   <= res_wval_q;
      out_acc_q    <= acc_q;
      out_status_q <= res_status_q;
      out_halt_q   <= res_halt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      line_q      <= '0;
      slot_ok_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          if (status == ST_OK) begin
            acc_q  <= acc_new;
            line_q <= nxt;
            if (we && a_in_range) begin
              slot_ok_q[vidx_q[AddrW-1:0]] <= 1'b1;
            end
          end
          state_q <= div_go ? S_DIV : S_FINISH;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            acc_q   <= div_res;
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_line_o   = out_line_q;
  assign write_valid_o = out_wvalid_q;
  assign write_value_o = out_wval_q;
  assign acc_value_o   = out_acc_q;
  assign status_o      = out_status_q;
  assign halted_o      = out_halt_q;

endmodule

// ===== design/am_div.sv =====
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
// depends on am_pkg for the request and response bundles

module am_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  am_pkg::div_req_t req_i,
  output am_pkg::div_rsp_t rsp_o
);
  import am_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  count_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] dvs_q;

  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic             fits;
  logic             last;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = !diff[DataW];
  assign last    = busy_q && !req_i.start && (count_q == CntW'(DataW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= last;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        count_q <= '0;
      end else if (busy_q) begin
        count_q <= count_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DataW-1:0] : shifted[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
